// ===== rtl/boiler_temperature_estimator_core_defines.svh =====
// Assertion macros for the boiler temperature estimator.
// Included by the top level; needs nothing else.
`ifndef BOILER_TEMPERATURE_ESTIMATOR_CORE_DEFINES_SVH
`define BOILER_TEMPERATURE_ESTIMATOR_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define BTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bte_pkg.sv =====
// Shared types and constants of the boiler temperature estimator.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package bte_pkg;

  // Field widths
  localparam int TEMP_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Dividend (ms times cooling factor) and divisor widths
  localparam int PROD_W = 47;
  localparam int DIV_W  = 34;
  localparam int K_W    = 15;

  // Divisors: 20000 ms per degree heating, 10752000000 for the cooling slope
  localparam logic [DIV_W-1:0] HEAT_DIV = 34'd20000;
  localparam logic [DIV_W-1:0] COOL_DIV = 34'd10752000000;

  // Outdoor clamp span and the base of the linear cooling factor (Q8.8)
  localparam logic signed [TEMP_W-1:0] COOL_LO   = -16'sd1280;
  localparam logic signed [TEMP_W-1:0] COOL_HI   = 16'sd7680;
  localparam logic signed [TEMP_W:0]   COOL_BASE = 17'sd16640;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST   = 16'sd23040;
  localparam logic signed [TEMP_W-1:0] FAULT_TEMP_RST = 16'sd25600;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_USE_MODEL  = 2'd0,
    REG_MAX_TEMP   = 2'd1,
    REG_FAULT_TEMP = 2'd2
  } bte_reg_t;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_CLAMP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } bte_state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bte_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bte_in_if.sv =====
// Input item channel of the boiler temperature estimator.
// Uses bte_pkg for field widths.
`default_nettype none

interface bte_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bte_pkg::TEMP_W-1:0]    sensor_one_temp;
  logic                                 sensor_one_valid;
  logic signed [bte_pkg::TEMP_W-1:0]    sensor_two_temp;
  logic                                 sensor_two_valid;
  logic                                 heater_on;
  logic signed [bte_pkg::TEMP_W-1:0]    outdoor_temp;
  logic        [bte_pkg::TIME_W-1:0]    now_ms;

  modport source (
    output valid, sensor_one_temp, sensor_one_valid, sensor_two_temp,
           sensor_two_valid, heater_on, outdoor_temp, now_ms,
    input  ready
  );

  modport sink (
    input  valid, sensor_one_temp, sensor_one_valid, sensor_two_temp,
           sensor_two_valid, heater_on, outdoor_temp, now_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/bte_out_if.sv =====
// Result item channel of the boiler temperature estimator.
// Uses bte_pkg for field widths.
`default_nettype none

interface bte_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bte_pkg::TEMP_W-1:0] water_temp;
  logic                              sensor_fault;
  logic                              model_seeded;

  modport source (
    output valid, water_temp, sensor_fault, model_seeded,
    input  ready
  );

  modport sink (
    input  valid, water_temp, sensor_fault, model_seeded,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/boiler_temperature_estimator_core.sv =====
// Boiler temperature estimator core; uses bte_pkg, the item interfaces and bte_sdiv.
// In sensor mode or while unseeded an accepted item goes from PREP to DONE; a model
// update also passes MUL, DIV (the bit-serial divide), UPD and CLAMP on its way.
// One item is taken at a time, only in the idle state;
// the next item is taken while a result waits in the output register, a further one
// waits in the done state. Synchronous active-low reset restores defaults and model.
`default_nettype none

`include "boiler_temperature_estimator_core_defines.svh"

module boiler_temperature_estimator_core #(
  parameter int MODEL_FRAC_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bte_in_if.sink                             in_item,
  bte_out_if.source                          out_item,
  input  wire logic                          cfg_we,
  input  wire logic [bte_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [bte_pkg::CFG_W-1:0]     cfg_data
);

  localparam int TW    = bte_pkg::TEMP_W;
  localparam int SHIFT = MODEL_FRAC_BITS - 8;
  localparam int MW    = MODEL_FRAC_BITS + 8;
  localparam int QW    = MODEL_FRAC_BITS + 18;
  localparam int SW    = MODEL_FRAC_BITS + 20;
  localparam int PW    = bte_pkg::PROD_W;
  localparam int KW    = bte_pkg::K_W;

  // Configuration registers
  logic                 use_model_r;
  logic signed [TW-1:0] max_temp_r;
  logic signed [TW-1:0] fault_temp_r;

  // Sequencer
  bte_pkg::bte_state_t  state_r;

  // Latched input item
  logic signed [TW-1:0] a_r, b_r, outdoor_r;
  logic                 av_r, bv_r, heat_r;
  logic [31:0]          now_r;

  // Model state
  logic signed [MW-1:0] model_r;
  logic                 seeded_r;
  logic [31:0]          last_time_r;
  logic signed [TW-1:0] held_r;

  // Working registers
  logic [31:0]          dt_r;
  logic [KW-1:0]        k_r;
  logic signed [SW-1:0] sum_r;
  logic                 fault_r;

  // Output register
  logic                 out_valid_r;
  logic signed [TW-1:0] out_temp_r;
  logic                 out_fault_r;
  logic                 out_seeded_r;

  // Combinational helpers
  logic signed [TW:0]   pair_sum;
  logic signed [TW-1:0] mean;
  logic                 have_mean;
  logic signed [TW-1:0] c_cl;
  logic signed [TW:0]   k_full;
  logic [PW-1:0]        dividend;
  logic [bte_pkg::DIV_W-1:0] divisor;
  logic                 div_start;
  bte_pkg::bte_div_stat_t div_stat;
  logic [QW-1:0]        step;
  logic signed [SW-1:0] model_ext;
  logic signed [SW-1:0] step_ext;
  logic signed [SW-1:0] cap_ext;
  logic signed [SW-1:0] floor_ext;
  logic signed [MW-1:0] model_new;
  logic                 out_free;

  // Mean of the valid sensors, floor of the halved sum
  always_comb begin
    pair_sum  = {a_r[TW-1], a_r} + {b_r[TW-1], b_r};
    have_mean = av_r || bv_r;
    if (av_r && bv_r) begin
      mean = pair_sum[TW:1];
    end else if (av_r) begin
      mean = a_r;
    end else begin
      mean = b_r;
    end
  end

  // Cooling factor: 16640 minus the clamped outdoor temperature
  always_comb begin
    if (outdoor_r < bte_pkg::COOL_LO) begin
      c_cl = bte_pkg::COOL_LO;
    end else if (outdoor_r > bte_pkg::COOL_HI) begin
      c_cl = bte_pkg::COOL_HI;
    end else begin
      c_cl = outdoor_r;
    end
    k_full = bte_pkg::COOL_BASE - {c_cl[TW-1], c_cl};
  end

  // Divider operands
  assign dividend  = heat_r ? PW'(dt_r) : PW'(dt_r) * PW'(k_r);
  assign divisor   = heat_r ? bte_pkg::HEAT_DIV : bte_pkg::COOL_DIV;
  assign div_start = state_r == bte_pkg::ST_MUL;

  bte_sdiv #(
    .FRAC_BITS (MODEL_FRAC_BITS),
    .QUOT_W    (QW)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (step)
  );

  // Widened operands for the update and the cap or floor compare
  always_comb begin
    model_ext = {{(SW-MW){model_r[MW-1]}}, model_r};
    step_ext  = {2'b00, step};
    cap_ext   = {{(SW-MW){max_temp_r[TW-1]}}, max_temp_r, {SHIFT{1'b0}}};
    floor_ext = {{(SW-MW){outdoor_r[TW-1]}}, outdoor_r, {SHIFT{1'b0}}};
    if (heat_r) begin
      model_new = (sum_r > cap_ext) ? cap_ext[MW-1:0] : sum_r[MW-1:0];
    end else begin
      model_new = (sum_r < floor_ext) ? floor_ext[MW-1:0] : sum_r[MW-1:0];
    end
  end

  assign out_free = !out_valid_r || out_item.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_model_r  <= 1'b0;
      max_temp_r   <= bte_pkg::MAX_TEMP_RST;
      fault_temp_r <= bte_pkg::FAULT_TEMP_RST;
    end else if (cfg_we) begin
      unique case (bte_pkg::bte_reg_t'(cfg_index))
        bte_pkg::REG_USE_MODEL:  use_model_r  <= cfg_data[0];
        bte_pkg::REG_MAX_TEMP:   max_temp_r   <= cfg_data;
        bte_pkg::REG_FAULT_TEMP: fault_temp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      a_r       <= in_item.sensor_one_temp;
      av_r      <= in_item.sensor_one_valid;
      b_r       <= in_item.sensor_two_temp;
      bv_r      <= in_item.sensor_two_valid;
      heat_r    <= in_item.heater_on;
      outdoor_r <= in_item.outdoor_temp;
      now_r     <= in_item.now_ms;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state_r == bte_pkg::ST_PREP) begin
      dt_r    <= now_r - last_time_r;
      k_r     <= k_full[KW-1:0];
      fault_r <= !have_mean;
    end
    if (state_r == bte_pkg::ST_UPD) begin
      sum_r <= heat_r ? model_ext + step_ext : model_ext - step_ext;
    end
  end

  // Sequencer and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bte_pkg::ST_IDLE;
      model_r     <= '0;
      seeded_r    <= 1'b0;
      last_time_r <= '0;
      held_r      <= '0;
    end else begin
      unique case (state_r)
        bte_pkg::ST_IDLE: begin
          if (in_item.valid) begin
            state_r <= bte_pkg::ST_PREP;
          end
        end
        bte_pkg::ST_PREP: begin
          if (!use_model_r) begin
            held_r   <= have_mean ? mean : fault_temp_r;
            seeded_r <= 1'b0;
            state_r  <= bte_pkg::ST_DONE;
          end else if (!seeded_r) begin
            if (have_mean) begin
              model_r     <= {mean, {SHIFT{1'b0}}};
              seeded_r    <= 1'b1;
              last_time_r <= now_r;
            end
            state_r <= bte_pkg::ST_DONE;
          end else begin
            last_time_r <= now_r;
            state_r     <= bte_pkg::ST_MUL;
          end
        end
        bte_pkg::ST_MUL: begin
          state_r <= bte_pkg::ST_DIV;
        end
        bte_pkg::ST_DIV: begin
          if (div_stat.done) begin
            state_r <= bte_pkg::ST_UPD;
          end
        end
        bte_pkg::ST_UPD: begin
          state_r <= bte_pkg::ST_CLAMP;
        end
        bte_pkg::ST_CLAMP: begin
          model_r <= model_new;
          held_r  <= model_new[MW-1:SHIFT];
          state_r <= bte_pkg::ST_DONE;
        end
        bte_pkg::ST_DONE: begin
          if (out_free) begin
            state_r <= bte_pkg::ST_IDLE;
          end
        end
        default: state_r <= bte_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register: load when free, drop valid once the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bte_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bte_pkg::ST_DONE && out_free) begin
      out_temp_r   <= held_r;
      out_fault_r  <= fault_r;
      out_seeded_r <= seeded_r;
    end
  end

  assign in_item.ready         = rst_n && state_r == bte_pkg::ST_IDLE;
  assign out_item.valid        = out_valid_r;
  assign out_item.water_temp   = out_temp_r;
  assign out_item.sensor_fault = out_fault_r;
  assign out_item.model_seeded = out_seeded_r;

  // Checks
  `BTE_ASSERT_IMPLY(a_ready_div_idle, clk, rst_n, in_item.ready, !div_stat.busy, "ready while divider busy")
  `BTE_ASSERT_IMPLY(a_done_in_div, clk, rst_n, div_stat.done, state_r == bte_pkg::ST_DIV, "divider done outside divide state")
  `BTE_ASSERT_NEXT(a_start_busy, clk, rst_n, div_start, div_stat.busy, "divider not busy after start")

endmodule

`default_nettype wire

// ===== rtl/bte_sdiv.sv =====
// Bit-serial restoring divider: floor(dividend * 2^FRAC_BITS / divisor).
// One quotient bit per cycle; uses bte_pkg for widths and the status struct.
`default_nettype none

module bte_sdiv #(
  parameter int FRAC_BITS = 32,
  parameter int QUOT_W    = 50
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bte_pkg::PROD_W-1:0]   dividend,
  input  wire logic [bte_pkg::DIV_W-1:0]    divisor,
  output bte_pkg::bte_div_stat_t            stat,
  output logic      [QUOT_W-1:0]            quotient
);

  localparam int PW    = bte_pkg::PROD_W;
  localparam int DW    = bte_pkg::DIV_W;
  localparam int STEPS = PW + FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic [PW-1:0]    num_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             take;
  logic             last;

  // Shift the next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem_r, num_r[PW-1]};
    diff  = trial - {1'b0, den_r};
    take  = trial >= {1'b0, den_r};
    last  = cnt_r == CNT_W'(STEPS - 1);
  end

  // Control: load on start, count the steps, drop busy after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dividend;
      den_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[PW-2:0], 1'b0};
      rem_r  <= take ? diff[DW-1:0] : trial[DW-1:0];
      quot_r <= {quot_r[QUOT_W-2:0], take};
    end
  end

  assign stat     = '{busy: busy_r, done: busy_r && last};
  assign quotient = quot_r;

endmodule

`default_nettype wire
